// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the search RTL.
// Depends on i_clk and i_rst_n in the module that includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, cond, cons) \
    `ASSERT_CLK(label, (cond) |-> (cons))

`endif

// ===== hdl/fsmatch_pkg.sv =====
// Types and constants for the first substring match block.
// No dependencies; used by the front, back and top modules.
package fsmatch_pkg;

    localparam int MAX_PATTERN_DEF = 128;
    localparam int MAX_TEXT_DEF    = 128;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int MAX_MATCH_INDEX = 127;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PATTERN = 2'd1;
    localparam logic [1:0] KIND_TEXT    = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic signed [7:0] MATCH_NONE = -8'sd1;

    typedef enum logic [1:0] {
        OP_START,
        OP_PATTERN,
        OP_TEXT,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] byte_value;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

// ===== hdl/fsmatch_front.sv =====
// Front end: accepts items, decodes the kind into an operation and queues it.
// Depends on fsmatch_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsmatch_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_in_kind,
    input  logic [7:0]           i_in_byte_value,
    output fsmatch_pkg::t_head   o_head,
    input  logic                 i_pop
);
    import fsmatch_pkg::*;

    t_entry                 r_q [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   w_push;
    logic                   w_pop;
    t_op                    w_op;

    always_comb begin
        unique case (i_in_kind)
            KIND_START:   w_op = OP_START;
            KIND_PATTERN: w_op = OP_PATTERN;
            KIND_TEXT:    w_op = OP_TEXT;
            KIND_END:     w_op = OP_END;
            default:      w_op = OP_START;
        endcase
    end

    assign o_in_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{op: w_op, byte_value: i_in_byte_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_q[r_rd];

    `ASSERT_CLK(a_count_bound, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLY(a_pop_nonempty, i_pop, r_count != '0)
    `ASSERT_IMPLY(a_ptr_gap, r_count == '0, r_wr == r_rd)

endmodule

// ===== hdl/fsmatch_back.sv =====
// Back end: pattern shift line, text window, lane compare and result register.
// Depends on fsmatch_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsmatch_back #(
    parameter int MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = fsmatch_pkg::MAX_TEXT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsmatch_pkg::t_head i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [7:0]  o_out_match_index,
    output logic               o_out_overflow
);
    import fsmatch_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PW = $clog2(MAX_TEXT + 1);

    logic [7:0]        r_pat [MAX_PATTERN];
    logic [7:0]        r_win [MAX_PATTERN];
    logic [7:0]        w_win_new [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_lane_hit;
    logic              w_eq;

    logic [LW-1:0]     r_len, n_len;
    logic [PW-1:0]     r_pos, n_pos;
    logic [PW-1:0]     r_mpos, n_mpos;
    logic              r_found, n_found;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    logic signed [7:0] r_out_idx, n_out_idx;
    logic              r_out_ovf, n_out_ovf;
    logic              w_shift_pat;
    logic              w_shift_win;
    logic [PW-1:0]     w_pos_inc;
    logic [7:0]        w_byte;

    assign w_byte    = i_head.entry.byte_value;
    assign w_pos_inc = PW'(32'(r_pos) + 1);

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < MAX_PATTERN - 1) begin
                w_win_new[i] = r_win[i + 1];
            end else begin
                w_win_new[i] = w_byte;
            end
            w_lane_hit[i] = (32'(r_len) + i < MAX_PATTERN) || (r_pat[i] == w_win_new[i]);
        end
    end

    assign w_eq  = &w_lane_hit;
    assign o_pop = i_head.valid &&
                   (i_head.entry.op != OP_END || !r_out_valid || i_out_ready);

    always_comb begin
        n_len       = r_len;
        n_pos       = r_pos;
        n_mpos      = r_mpos;
        n_found     = r_found;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_idx   = r_out_idx;
        n_out_ovf   = r_out_ovf;
        w_shift_pat = 1'b0;
        w_shift_win = 1'b0;
        if (o_pop) begin
            unique case (i_head.entry.op)
                OP_START: begin
                    n_len   = '0;
                    n_pos   = '0;
                    n_mpos  = '0;
                    n_found = 1'b0;
                    n_ovf   = 1'b0;
                end
                OP_PATTERN: begin
                    if (32'(r_len) < MAX_PATTERN) begin
                        w_shift_pat = 1'b1;
                        n_len       = LW'(32'(r_len) + 1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_TEXT: begin
                    if (32'(r_pos) < MAX_TEXT) begin
                        w_shift_win = 1'b1;
                        n_pos       = w_pos_inc;
                        if (!r_found && r_len != '0 &&
                            32'(w_pos_inc) >= 32'(r_len) && w_eq) begin
                            n_found = 1'b1;
                            n_mpos  = PW'(32'(w_pos_inc) - 32'(r_len));
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_END: begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_ovf;
                    if (r_len == '0) begin
                        n_out_idx = '0;
                    end else if (r_found) begin
                        if (32'(r_mpos) > MAX_MATCH_INDEX) begin
                            n_out_idx = 8'(MAX_MATCH_INDEX);
                            n_out_ovf = 1'b1;
                        end else begin
                            n_out_idx = 8'(r_mpos);
                        end
                    end else begin
                        n_out_idx = MATCH_NONE;
                    end
                    n_pos   = '0;
                    n_mpos  = '0;
                    n_found = 1'b0;
                    n_ovf   = 1'b0;
                end
                default: begin
                    n_ovf = r_ovf;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift_pat) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_pat[i] <= r_pat[i + 1];
            end
            r_pat[MAX_PATTERN - 1] <= w_byte;
        end
        if (w_shift_win) begin
            r_win <= w_win_new;
        end
        r_out_idx <= n_out_idx;
        r_out_ovf <= n_out_ovf;
        r_mpos    <= n_mpos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_found     <= n_found;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_match_index = r_out_idx;
    assign o_out_overflow    = r_out_ovf;

    `ASSERT_IMPLY(a_found_cons, r_found, r_len != '0 && r_mpos < r_pos)
    `ASSERT_IMPLY(a_end_slot, o_pop && i_head.entry.op == OP_END,
        !r_out_valid || i_out_ready)
    `ASSERT_CLK(a_bounds, 32'(r_len) <= MAX_PATTERN && 32'(r_pos) <= MAX_TEXT)

endmodule

// ===== hdl/first_substring_match.sv =====
// First substring match: streaming search for the first pattern occurrence in a text.
// Throughput one item per cycle while the queue has room; every item takes one pass of the
// back-end window compare. An end item's result is registered when the back end pops it.
// An end item waits in the queue while the previous result is held and not taken.
// Reset clears pattern length, text position, flags, queue and result valid;
// pattern and window bytes are not cleared.
module first_substring_match #(
    parameter int MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = fsmatch_pkg::MAX_TEXT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_in_kind,
    input  logic [7:0]        i_in_byte_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [7:0] o_out_match_index,
    output logic              o_out_overflow
);
    import fsmatch_pkg::*;

    t_head w_head;
    logic  w_pop;

    fsmatch_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_kind       (i_in_kind),
        .i_in_byte_value (i_in_byte_value),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    fsmatch_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_match_index (o_out_match_index),
        .o_out_overflow    (o_out_overflow)
    );

endmodule
